// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// clocked assertion helpers shared by the point-in-polygon rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define PIP_ASSERT(label, clock, reset, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) prop) \
    else $error(msg);

// condition must never be seen at a rising edge outside reset
`define PIP_ASSERT_NEVER(label, clock, reset, cond, msg) \
  `PIP_ASSERT(label, clock, reset, !(cond), msg)

`endif

// ----- sv/pip_pkg.sv -----
// ----------------------------------------------------------------------------
// pip_pkg
// shared types and constants of the point-in-polygon test
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pip_pkg;

  localparam int COORD_W = 24;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;

  // queue depths must be powers of two, pointers wrap naturally
  localparam int CQ_DEPTH = 4;
  localparam int CQ_AW    = $clog2(CQ_DEPTH);
  localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  localparam int MIN_VERTS = 3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic [1:0]                vcount_t;

  localparam vcount_t VCNT_ZERO = 2'd0;
  localparam vcount_t VCNT_ONE  = 2'd1;
  localparam vcount_t VCNT_MAX  = vcount_t'(MIN_VERTS);
  localparam vcount_t VCNT_OK   = vcount_t'(MIN_VERTS - 1);

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  // one vertex after classification by the front end
  typedef struct packed {
    point_t cur;
    point_t prev;
    point_t first;
    point_t query;
    logic   new_poly;
    logic   has_a;
    logic   last;
    logic   degen;
  } cmd_t;

  typedef struct packed {
    logic contains;
    logic degenerate;
  } result_t;

endpackage

`default_nettype wire

// ----- sv/pip_front.sv -----
// ----------------------------------------------------------------------------
// pip_front
// accepts vertex words, tracks first/previous vertex and query point,
// and issues edge commands to the back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pip_front import pip_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  output logic        full,
  input  wire coord_t vertex_x,
  input  wire coord_t vertex_y,
  input  wire coord_t query_x,
  input  wire coord_t query_y,
  input  wire logic   last_vertex,
  output logic        cmd_push,
  output cmd_t        cmd,
  input  wire logic   cmd_full
);

  vcount_t count;
  vcount_t count_next;
  point_t  first_v;
  point_t  prev_v;
  point_t  query_v;
  point_t  cur;
  point_t  q_in;
  logic    is_new;
  logic    take;

  assign full     = cmd_full;
  assign take     = push && !cmd_full;
  assign cmd_push = take;

  always_comb begin
    cur.x  = vertex_x;
    cur.y  = vertex_y;
    q_in.x = query_x;
    q_in.y = query_y;
    is_new = (count == VCNT_ZERO);

    cmd.cur      = cur;
    cmd.prev     = prev_v;
    cmd.first    = is_new ? cur : first_v;
    cmd.query    = is_new ? q_in : query_v;
    cmd.new_poly = is_new;
    cmd.has_a    = !is_new;
    cmd.last     = last_vertex;
    // fewer than three vertices once this one is counted
    cmd.degen    = (count < VCNT_OK);

    if (last_vertex) begin
      count_next = VCNT_ZERO;
    end else if (count == VCNT_MAX) begin
      count_next = count;
    end else begin
      count_next = count + VCNT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= VCNT_ZERO;
    end else if (take) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      prev_v <= cur;
      if (is_new) begin
        first_v <= cur;
        query_v <= q_in;
      end
    end
  end

  `PIP_ASSERT(a_last_restarts, clk, rst, (take && last_vertex) |=> (count == VCNT_ZERO), "count not cleared after final vertex")
  `PIP_ASSERT(a_count_sat, clk, rst, (take && !last_vertex && count == VCNT_MAX) |=> (count == VCNT_MAX), "vertex count left saturation")

endmodule

`default_nettype wire

// ----- sv/pip_cmd_queue.sv -----
// ----------------------------------------------------------------------------
// pip_cmd_queue
// short command queue between front and back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pip_cmd_queue import pip_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr,
  input  wire cmd_t wr_data,
  output logic      full,
  input  wire logic rd,
  output cmd_t      rd_data,
  output logic      empty
);

  cmd_t             slots [CQ_DEPTH];
  logic [CQ_AW-1:0] wr_ptr;
  logic [CQ_AW-1:0] rd_ptr;
  logic [CQ_CW-1:0] cnt;
  logic             wr_fire;
  logic             rd_fire;

  assign full    = (cnt == CQ_CW'(CQ_DEPTH));
  assign empty   = (cnt == '0);
  assign wr_fire = wr && !full;
  assign rd_fire = rd && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (wr_fire) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_fire) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({wr_fire, rd_fire})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  `PIP_ASSERT(a_cq_grow, clk, rst, (wr_fire && !rd_fire) |=> (cnt == $past(cnt) + 1'b1), "command queue count did not grow")
  `PIP_ASSERT_NEVER(a_cq_over, clk, rst, cnt > CQ_CW'(CQ_DEPTH), "command queue overfilled")

endmodule

`default_nettype wire

// ----- sv/pip_back.sv -----
// ----------------------------------------------------------------------------
// pip_back
// edge tests for each command: products, then compare and parity update,
// with a small result queue on the output side
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pip_back import pip_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cmd_t cmd,
  input  wire logic cmd_empty,
  output logic      cmd_pop,
  input  wire logic pop,
  output logic      empty,
  output logic      contains,
  output logic      degenerate
);

  typedef struct packed {
    prod_t ex_py;
    prod_t ey_px;
    logic  in_box;
    logic  straddle;
    logic  ey_pos;
  } edge_t;

  function automatic edge_t edge_prep(point_t a, point_t b, point_t q);
    diff_t  ex;
    diff_t  ey;
    diff_t  px;
    diff_t  py;
    coord_t lox;
    coord_t hix;
    coord_t loy;
    coord_t hiy;
    edge_t  e;
    ex  = diff_t'($signed(b.x)) - diff_t'($signed(a.x));
    ey  = diff_t'($signed(b.y)) - diff_t'($signed(a.y));
    px  = diff_t'($signed(q.x)) - diff_t'($signed(a.x));
    py  = diff_t'($signed(q.y)) - diff_t'($signed(a.y));
    lox = ($signed(a.x) < $signed(b.x)) ? a.x : b.x;
    hix = ($signed(a.x) < $signed(b.x)) ? b.x : a.x;
    loy = ($signed(a.y) < $signed(b.y)) ? a.y : b.y;
    hiy = ($signed(a.y) < $signed(b.y)) ? b.y : a.y;
    e.ex_py    = prod_t'(ex) * prod_t'(py);
    e.ey_px    = prod_t'(ey) * prod_t'(px);
    e.in_box   = ($signed(q.x) >= lox) && ($signed(q.x) <= hix) &&
                 ($signed(q.y) >= loy) && ($signed(q.y) <= hiy);
    e.straddle = ($signed(a.y) > $signed(q.y)) != ($signed(b.y) > $signed(q.y));
    e.ey_pos   = !ey[DIFF_W-1] && (ey != '0);
    return e;
  endfunction

  // product stage
  logic  s1_valid;
  edge_t s1_ea;
  edge_t s1_eb;
  logic  s1_new;
  logic  s1_has_a;
  logic  s1_last;
  logic  s1_degen;

  // commit stage
  logic  parity;
  logic  on_edge;
  logic  par_base;
  logic  on_base;
  logic  par_next;
  logic  on_next;
  logic  on_a;
  logic  on_b;
  logic  tog_a;
  logic  tog_b;
  logic  commit;
  logic  s1_adv;

  // result queue
  result_t          oq [OQ_DEPTH];
  logic [OQ_AW-1:0] oq_wr;
  logic [OQ_AW-1:0] oq_rd;
  logic [OQ_CW-1:0] oq_cnt;
  logic             oq_full;
  logic             oq_push;
  logic             oq_pop;
  result_t          res;

  assign oq_full = (oq_cnt == OQ_CW'(OQ_DEPTH));
  assign empty   = (oq_cnt == '0);
  assign oq_pop  = pop && !empty;
  assign commit  = s1_valid && (!s1_last || !oq_full);
  assign s1_adv  = !s1_valid || commit;
  assign cmd_pop = s1_adv;
  assign oq_push = commit && s1_last;

  always_comb begin
    on_a  = s1_ea.in_box && (s1_ea.ex_py == s1_ea.ey_px);
    on_b  = s1_eb.in_box && (s1_eb.ex_py == s1_eb.ey_px);
    // crossing lies right of the query point, direction set by sign of dy
    tog_a = s1_ea.straddle && (s1_ea.ey_pos ? ($signed(s1_ea.ey_px) < $signed(s1_ea.ex_py))
                                            : ($signed(s1_ea.ex_py) < $signed(s1_ea.ey_px)));
    tog_b = s1_eb.straddle && (s1_eb.ey_pos ? ($signed(s1_eb.ey_px) < $signed(s1_eb.ex_py))
                                            : ($signed(s1_eb.ex_py) < $signed(s1_eb.ey_px)));
    par_base = s1_new ? 1'b0 : parity;
    on_base  = s1_new ? 1'b0 : on_edge;
    par_next = par_base ^ (tog_a && s1_has_a) ^ (tog_b && s1_last);
    on_next  = on_base | (on_a && s1_has_a) | (on_b && s1_last);
    res.contains   = !s1_degen && (on_next || par_next);
    res.degenerate = s1_degen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      parity   <= 1'b0;
      on_edge  <= 1'b0;
      oq_wr    <= '0;
      oq_rd    <= '0;
      oq_cnt   <= '0;
    end else begin
      if (s1_adv) begin
        s1_valid <= !cmd_empty;
      end
      if (commit) begin
        parity  <= par_next;
        on_edge <= on_next;
      end
      if (oq_push) begin
        oq_wr <= oq_wr + 1'b1;
      end
      if (oq_pop) begin
        oq_rd <= oq_rd + 1'b1;
      end
      unique case ({oq_push, oq_pop})
        2'b10:   oq_cnt <= oq_cnt + 1'b1;
        2'b01:   oq_cnt <= oq_cnt - 1'b1;
        default: oq_cnt <= oq_cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && !cmd_empty) begin
      s1_ea    <= edge_prep(cmd.prev, cmd.cur, cmd.query);
      s1_eb    <= edge_prep(cmd.cur, cmd.first, cmd.query);
      s1_new   <= cmd.new_poly;
      s1_has_a <= cmd.has_a;
      s1_last  <= cmd.last;
      s1_degen <= cmd.degen;
    end
    if (oq_push) begin
      oq[oq_wr] <= res;
    end
  end

  assign contains   = oq[oq_rd].contains;
  assign degenerate = oq[oq_rd].degenerate;

  `PIP_ASSERT_NEVER(a_degen_excl, clk, rst, !empty && contains && degenerate, "degenerate result marked as contains")
  `PIP_ASSERT_NEVER(a_oq_over, clk, rst, oq_cnt > OQ_CW'(OQ_DEPTH), "result queue overfilled")
  `PIP_ASSERT(a_stall_hold, clk, rst, (s1_valid && !commit) |=> s1_valid, "stalled command dropped")

endmodule

`default_nettype wire

// ----- sv/point_in_polygon_test.sv -----
// ----------------------------------------------------------------------------
// point_in_polygon_test
// even-odd ray casting point-in-polygon test over a stream of vertices
// ----------------------------------------------------------------------------
// Vertices of one polygon are pushed one word per cycle; the query point is
// taken from the first word of each polygon and the word with last_vertex set
// closes the polygon (the closing edge back to the first vertex is tested
// too). One result word per polygon: contains is set when the point is inside
// or on any edge, degenerate is set (and contains clear) for fewer than three
// vertices. The block takes one vertex per clock while the command queue has
// room; each vertex is classified as it is accepted and written straight into
// a 4-entry command queue, then passes one product stage (two 25x25 signed
// multiplies per edge), whose compare and parity logic writes the result
// queue, stalling on a final vertex while that queue is full; a result thus
// passes the command queue, the product stage and the result queue before it
// shows on the result ports, where it can be popped. A 4-entry result queue
// absorbs stalls on the pop side; full is raised whenever the command queue is full.
`timescale 1ns / 1ps
`default_nettype none

module point_in_polygon_test import pip_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  output logic        full,
  input  wire coord_t vertex_x,
  input  wire coord_t vertex_y,
  input  wire coord_t query_x,
  input  wire coord_t query_y,
  input  wire logic   last_vertex,
  output logic        empty,
  input  wire logic   pop,
  output logic        contains,
  output logic        degenerate
);

  cmd_t fe_cmd;
  cmd_t cq_cmd;
  logic fe_push;
  logic cq_full;
  logic cq_empty;
  logic cq_pop;

  pip_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .vertex_x    (vertex_x),
    .vertex_y    (vertex_y),
    .query_x     (query_x),
    .query_y     (query_y),
    .last_vertex (last_vertex),
    .cmd_push    (fe_push),
    .cmd         (fe_cmd),
    .cmd_full    (cq_full)
  );

  pip_cmd_queue u_cmd_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (fe_push),
    .wr_data (fe_cmd),
    .full    (cq_full),
    .rd      (cq_pop),
    .rd_data (cq_cmd),
    .empty   (cq_empty)
  );

  pip_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cq_cmd),
    .cmd_empty  (cq_empty),
    .cmd_pop    (cq_pop),
    .pop        (pop),
    .empty      (empty),
    .contains   (contains),
    .degenerate (degenerate)
  );

endmodule

`default_nettype wire
